### src/acr_pkg.sv
// Shared constants, register indexes and helper functions for the channel reorder block.
package acr_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int CODE_BITS    = 6;
  localparam int IDX_W        = $clog2(MAX_CHANNELS);
  localparam int COUNT_W      = 4;
  localparam int MAP_W        = 48;
  localparam int SAMPLE_W     = 64;
  localparam int PCM_W        = 16;
  localparam int SUM_W        = PCM_W + IDX_W;
  localparam int DIV_CNT_W    = $clog2(SUM_W + 1);
  localparam int REG_IDX_W    = 3;

  localparam logic [REG_IDX_W-1:0] REG_BYPASS      = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FORMAT      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_IN_COUNT    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OUT_COUNT   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_IN_MAP      = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_OUT_MAP     = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_CODE = 3'd6;

  localparam logic [1:0] FMT_8  = 2'd0;
  localparam logic [1:0] FMT_16 = 2'd1;
  localparam logic [1:0] FMT_32 = 2'd2;
  localparam logic [1:0] FMT_64 = 2'd3;

  function automatic logic [SAMPLE_W-1:0] format_mask(input logic [1:0] fmt);
    logic [SAMPLE_W-1:0] m;
    begin
      case (fmt)
        FMT_8:   m = 64'h0000_0000_0000_00FF;
        FMT_16:  m = 64'h0000_0000_0000_FFFF;
        FMT_32:  m = 64'h0000_0000_FFFF_FFFF;
        default: m = 64'hFFFF_FFFF_FFFF_FFFF;
      endcase
      return m;
    end
  endfunction

  function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] c);
    logic [COUNT_W-1:0] r;
    begin
      if (c == '0) r = COUNT_W'(1);
      else if (c > COUNT_W'(MAX_CHANNELS)) r = COUNT_W'(MAX_CHANNELS);
      else r = c;
      return r;
    end
  endfunction

  function automatic logic [CODE_BITS-1:0] code_of(input logic [MAP_W-1:0] map,
                                                   input logic [IDX_W-1:0] k);
    logic [CODE_BITS-1:0] c;
    begin
      c = map[k*CODE_BITS +: CODE_BITS];
      return c;
    end
  endfunction

endpackage

### src/audio_channel_reorder.sv
// Top level of the audio channel reorder / downmix block.
//
// Input channel: sample_valid / sample_stall / sample, one interleaved sample per request.
// Output channel: result_valid / result_stall / out_sample / frame_end, one sample per request.
// Configuration: cfg_write/cfg_index/cfg_data; user writes while the block is idle (unchecked).
// Bypass: each sample leaves through the output register in the cycle after it is taken;
//   frame_end is set on every one. A new sample is taken while the output register is
//   free or being emptied in that cycle.
// Reorder: samples are written into an 8-entry frame memory, one per cycle. The last
//   sample of a frame starts the output run: each output channel takes a memory read
//   plus an output load.
// Downmix (16-bit, one output): a read and an accumulate per input channel, a setup state,
//   then a bit-serial divide of the sum by the input count and the output load.
// The input stalls while a frame's outputs are produced; the frame memory read port
//   sets the pace. A stalled result holds in the output register and the sequencer waits.
// Reset: registers return to bypass, 16-bit, two channels in and out, zero maps and
//   center code; frame position and output valid clear. The frame memory is not cleared.
module audio_channel_reorder (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  logic [acr_pkg::SAMPLE_W-1:0]       sample,
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic [acr_pkg::SAMPLE_W-1:0]       out_sample,
  output logic                               frame_end,
  input  logic                               cfg_write,
  input  logic [acr_pkg::REG_IDX_W-1:0]      cfg_index,
  input  logic [acr_pkg::MAP_W-1:0]          cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAP_RD,
    S_MAP_OUT,
    S_SUM_RD,
    S_SUM_ACC,
    S_DIV_GO,
    S_DIV,
    S_DMX_OUT
  } state_t;

  state_t                             state;

  logic                               bypass;
  logic [1:0]                         sample_format;
  logic [acr_pkg::COUNT_W-1:0]        in_count;
  logic [acr_pkg::COUNT_W-1:0]        out_count;
  logic [acr_pkg::MAP_W-1:0]          in_map;
  logic [acr_pkg::MAP_W-1:0]          out_map;
  logic [acr_pkg::CODE_BITS-1:0]      center_code;

  logic [acr_pkg::SAMPLE_W-1:0]       frame_store [acr_pkg::MAX_CHANNELS];
  logic [acr_pkg::SAMPLE_W-1:0]       rd_data;
  logic                               mem_we;
  logic                               mem_re;
  logic [acr_pkg::IDX_W-1:0]          rd_addr;

  logic [acr_pkg::IDX_W-1:0]          pos;
  logic [acr_pkg::IDX_W-1:0]          idx;
  logic                               map_hit;
  logic signed [acr_pkg::SUM_W-1:0]   sum;
  logic signed [acr_pkg::SUM_W-1:0]   sum_next;
  logic                               sum_neg;
  logic [acr_pkg::SUM_W-1:0]          sum_mag;
  logic [acr_pkg::SUM_W-1:0]          avg;

  logic [acr_pkg::SAMPLE_W-1:0]       mask;
  logic [acr_pkg::COUNT_W-1:0]        in_n;
  logic [acr_pkg::COUNT_W-1:0]        out_n;
  logic                               accept;
  logic                               out_free;
  logic                               out_load;
  logic                               frame_last;
  logic                               idx_last_out;
  logic                               idx_last_in;
  logic                               match_hit;
  logic [acr_pkg::IDX_W-1:0]          match_idx;

  logic                               dv_start;
  logic                               dv_done;
  logic [acr_pkg::SUM_W-1:0]          dv_quo;

  assign mask         = acr_pkg::format_mask(sample_format);
  assign in_n         = acr_pkg::clamp_count(in_count);
  assign out_n        = acr_pkg::clamp_count(out_count);
  assign out_free     = !result_valid || !result_stall;
  assign sample_stall = !((state == S_IDLE) && (!bypass || out_free));
  assign accept       = sample_valid && !sample_stall;
  assign out_load     = out_free && (((state == S_IDLE) && accept && bypass) ||
                                     (state == S_MAP_OUT) || (state == S_DMX_OUT));
  assign frame_last   = ({1'b0, pos} + acr_pkg::COUNT_W'(1)) >= in_n;
  assign idx_last_out = ({1'b0, idx} + acr_pkg::COUNT_W'(1)) == out_n;
  assign idx_last_in  = ({1'b0, idx} + acr_pkg::COUNT_W'(1)) == in_n;

  assign mem_we  = accept && !bypass;
  assign mem_re  = (state == S_MAP_RD) || (state == S_SUM_RD);
  assign rd_addr = (state == S_MAP_RD) ? match_idx : idx;

  assign sum_next = sum + acr_pkg::SUM_W'(signed'(rd_data[acr_pkg::PCM_W-1:0]));
  assign sum_neg  = sum[acr_pkg::SUM_W-1];
  assign sum_mag  = sum_neg ? acr_pkg::SUM_W'(-sum) : acr_pkg::SUM_W'(sum);
  assign avg      = sum_neg ? (~dv_quo + 1'b1) : dv_quo;
  assign dv_start = (state == S_DIV_GO);

  // first input channel with the code of output channel idx; a lone center_code input matches all
  always_comb begin
    match_hit = 1'b0;
    match_idx = '0;
    if (in_n == acr_pkg::COUNT_W'(1) &&
        acr_pkg::code_of(in_map, acr_pkg::IDX_W'(0)) == center_code) begin
      match_hit = 1'b1;
    end else begin
      for (int j = acr_pkg::MAX_CHANNELS - 1; j >= 0; j--) begin
        if (acr_pkg::COUNT_W'(j) < in_n &&
            acr_pkg::code_of(in_map, acr_pkg::IDX_W'(j)) ==
            acr_pkg::code_of(out_map, idx)) begin
          match_hit = 1'b1;
          match_idx = acr_pkg::IDX_W'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_store[pos] <= sample & mask;
    end
    if (mem_re) begin
      rd_data <= frame_store[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bypass        <= 1'b1;
      sample_format <= acr_pkg::FMT_16;
      in_count      <= acr_pkg::COUNT_W'(2);
      out_count     <= acr_pkg::COUNT_W'(2);
      in_map        <= '0;
      out_map       <= '0;
      center_code   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        acr_pkg::REG_BYPASS:      bypass        <= cfg_data[0];
        acr_pkg::REG_FORMAT:      sample_format <= cfg_data[1:0];
        acr_pkg::REG_IN_COUNT:    in_count      <= cfg_data[acr_pkg::COUNT_W-1:0];
        acr_pkg::REG_OUT_COUNT:   out_count     <= cfg_data[acr_pkg::COUNT_W-1:0];
        acr_pkg::REG_IN_MAP:      in_map        <= cfg_data;
        acr_pkg::REG_OUT_MAP:     out_map       <= cfg_data;
        acr_pkg::REG_CENTER_CODE: center_code   <= cfg_data[acr_pkg::CODE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      pos          <= '0;
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && !out_load) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (bypass) begin
              pos          <= '0;
              result_valid <= 1'b1;
              out_sample   <= sample & mask;
              frame_end    <= 1'b1;
            end else if (!frame_last) begin
              pos <= pos + 1'b1;
            end else begin
              pos <= '0;
              idx <= '0;
              sum <= '0;
              if (sample_format == acr_pkg::FMT_16 && out_n == acr_pkg::COUNT_W'(1)) begin
                state <= S_SUM_RD;
              end else begin
                state <= S_MAP_RD;
              end
            end
          end
        end
        S_MAP_RD: begin
          map_hit <= match_hit;
          state   <= S_MAP_OUT;
        end
        S_MAP_OUT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            out_sample   <= map_hit ? (rd_data & mask) : '0;
            frame_end    <= idx_last_out;
            if (idx_last_out) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_MAP_RD;
            end
          end
        end
        S_SUM_RD: begin
          state <= S_SUM_ACC;
        end
        S_SUM_ACC: begin
          sum <= sum_next;
          if (idx_last_in) begin
            state <= S_DIV_GO;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SUM_RD;
          end
        end
        S_DIV_GO: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (dv_done) begin
            state <= S_DMX_OUT;
          end
        end
        S_DMX_OUT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            out_sample   <= acr_pkg::SAMPLE_W'(avg[acr_pkg::PCM_W-1:0]);
            frame_end    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  acr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (sum_mag),
    .divisor  (in_n),
    .done     (dv_done),
    .quotient (dv_quo)
  );

`ifndef SYNTHESIS
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> sample_stall)
    else $error("input taken while a frame is being emitted");

  a_bypass_result: assert property (@(posedge clk) disable iff (rst)
    accept && bypass |=> result_valid && frame_end)
    else $error("bypass sample did not reach the output register");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    dv_done |-> state == S_DIV)
    else $error("divider finished outside the divide state");

  a_map_load: assert property (@(posedge clk) disable iff (rst)
    state == S_MAP_OUT && out_free |=> result_valid)
    else $error("remapped sample not loaded");
`endif

endmodule

### src/acr_div.sv
// Bit-serial restoring divider for the downmix average, one quotient bit per cycle.
module acr_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [acr_pkg::SUM_W-1:0]           dividend,
  input  logic [acr_pkg::COUNT_W-1:0]         divisor,
  output logic                                done,
  output logic [acr_pkg::SUM_W-1:0]           quotient
);

  logic                              running;
  logic [acr_pkg::DIV_CNT_W-1:0]     cnt;
  logic [acr_pkg::IDX_W-1:0]         rem;
  logic [acr_pkg::IDX_W:0]           shifted;
  logic                              ge;
  logic [acr_pkg::IDX_W:0]           diff;

  assign shifted = {rem, quotient[acr_pkg::SUM_W-1]};
  assign ge      = shifted >= divisor;
  assign diff    = shifted - divisor;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running  <= 1'b1;
        cnt      <= acr_pkg::DIV_CNT_W'(acr_pkg::SUM_W);
        rem      <= '0;
        quotient <= dividend;
      end else if (running) begin
        rem      <= ge ? diff[acr_pkg::IDX_W-1:0] : shifted[acr_pkg::IDX_W-1:0];
        quotient <= {quotient[acr_pkg::SUM_W-2:0], ge};
        cnt      <= cnt - 1'b1;
        if (cnt == acr_pkg::DIV_CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule
